// File: src/dmc_pkg.sv
// Shared sizes, types and codes for the direct-mapped cache read unit.
package dmc_pkg;

    localparam int NUM_LINES    = 4;
    localparam int LINE_BYTES   = 8;
    localparam int MEMORY_BYTES = 1024;

    localparam int DATA_W   = 8;
    localparam int CNT_W    = 32;
    localparam int WORD_W   = $clog2(LINE_BYTES);
    localparam int LINE_W   = $clog2(NUM_LINES);
    localparam int ADDR_W   = $clog2(MEMORY_BYTES);
    localparam int TAG_W    = ADDR_W - LINE_W - WORD_W;
    localparam int CACHE_AW = LINE_W + WORD_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int S_TDATA_W = ((ADDR_W + DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_W + 2 * CNT_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0]  MISS_PENALTY = CNT_W'(10);
    localparam logic [WORD_W-1:0] WORD_LAST    = WORD_W'(LINE_BYTES - 1);

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_READ = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [TAG_W-1:0]    tag;
        logic [LINE_W-1:0]   line;
        logic [WORD_W-1:0]   word;
        logic [DATA_W-1:0]   wbyte;
    } t_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_READ,
        ST_OUT
    } t_state;

endpackage

// File: src/direct_mapped_cache_read_unit.sv
// Top level of the direct-mapped cache read unit.
// Read-only direct-mapped cache (4 lines of 8 bytes) in front of a 1024-byte backing
// memory. A beat with tuser low stores write_byte into backing memory; a beat with
// tuser high reads the addressed byte through the cache and returns it with a hit
// flag, the running miss count and the simulated time. Every beat yields exactly one
// result beat. Beats pass an input register and a two-entry queue, then a sequencer
// serves them one at a time; a read miss first runs a refill that pulls the 8-byte
// block through the single read port of the backing memory one byte per cycle.
// Input and output stall independently; a waiting result does not block new beats
// from being queued.
module direct_mapped_cache_read_unit
    import dmc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // address[9:0], write_byte[17:10], zero pad
    input  logic                 i_s_tuser,  // action
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,  // read_byte[7:0], miss_total[39:8],
                                             // elapsed_time[71:40]
    output logic                 o_m_tuser   // was_hit
);

    logic  front_push;
    t_item front_item;
    logic  q_ready;
    logic  q_valid;
    t_item q_item;
    logic  q_pop;

    dmc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_push     (front_push),
        .o_item     (front_item),
        .i_q_ready  (q_ready)
    );

    dmc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_item  (front_item),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    dmc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_item   (q_item),
        .o_q_pop    (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

// File: src/dmc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/dmc_queue.sv
// Short FIFO of decoded items between the front and the back of the cache unit.
module dmc_queue
    import dmc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_ready,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              push_ok;
    logic              pop_ok;

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push_ok) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop_ok) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// File: src/dmc_front.sv
// Input stage: takes stream beats, splits the address and classifies the access.
module dmc_front
    import dmc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic                 i_s_tuser,
    output logic                 o_push,
    output t_item                o_item,
    input  logic                 i_q_ready
);

    logic  r_valid, n_valid;
    t_item r_item;
    t_item dec_item;
    logic  take;

    assign o_s_tready = !r_valid || i_q_ready;
    assign take       = i_s_tvalid && o_s_tready;

    always_comb begin
        dec_item.kind  = i_s_tuser ? KIND_READ : KIND_LOAD;
        dec_item.tag   = i_s_tdata[ADDR_W-1 -: TAG_W];
        dec_item.line  = i_s_tdata[WORD_W +: LINE_W];
        dec_item.word  = i_s_tdata[WORD_W-1:0];
        dec_item.wbyte = i_s_tdata[ADDR_W +: DATA_W];
    end

    always_comb begin
        n_valid = r_valid;
        if (take) begin
            n_valid = 1'b1;
        end else if (i_q_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= dec_item;
        end
    end

    assign o_push = r_valid;
    assign o_item = r_item;

endmodule

// File: src/dmc_back.sv
// Back end: tag check, line refill from backing memory, counters and result register.
module dmc_back
    import dmc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  t_item                i_q_item,
    output logic                 o_q_pop,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,
    output logic                 o_m_tuser
);

    t_state              r_state, n_state;
    t_item               r_item, n_item;
    logic [WORD_W-1:0]   r_cnt, n_cnt;
    logic [TAG_W-1:0]    r_tag [NUM_LINES];
    logic [TAG_W-1:0]    n_tag [NUM_LINES];
    logic [NUM_LINES-1:0] r_lvalid, n_lvalid;
    logic [CNT_W-1:0]    r_miss, n_miss;
    logic [CNT_W-1:0]    r_time, n_time;
    logic [DATA_W-1:0]   r_byte, n_byte;
    logic                r_hit, n_hit;
    logic                r_out_valid, n_out_valid;
    logic [DATA_W-1:0]   r_out_byte;
    logic                r_out_hit;
    logic [CNT_W-1:0]    r_out_miss;
    logic [CNT_W-1:0]    r_out_time;
    logic                out_load;
    logic                hit_now;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [DATA_W-1:0]   mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [DATA_W-1:0]   mem_rdata;
    logic                line_we;
    logic [CACHE_AW-1:0] line_waddr;
    logic [CACHE_AW-1:0] line_raddr;
    logic [DATA_W-1:0]   line_rdata;

    dmc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEMORY_BYTES)
    ) u_backing (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    dmc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_LINES * LINE_BYTES)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr (line_waddr),
        .i_wdata (mem_rdata),
        .i_raddr (line_raddr),
        .o_rdata (line_rdata)
    );

    assign hit_now  = r_lvalid[i_q_item.line] && (r_tag[i_q_item.line] == i_q_item.tag);
    assign out_load = (r_state == ST_OUT) && (!r_out_valid || i_m_tready);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_item.kind == KIND_LOAD) begin
                        n_state = ST_OUT;
                    end else if (hit_now) begin
                        n_state = ST_READ;
                    end else begin
                        n_state = ST_FILL;
                    end
                end
            end
            ST_FILL: begin
                if (r_cnt == WORD_LAST) begin
                    n_state = ST_OUT;
                end
            end
            ST_READ: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb begin
        o_q_pop    = 1'b0;
        n_item     = r_item;
        n_cnt      = r_cnt;
        n_tag      = r_tag;
        n_lvalid   = r_lvalid;
        n_miss     = r_miss;
        n_time     = r_time;
        n_byte     = r_byte;
        n_hit      = r_hit;
        mem_we     = 1'b0;
        mem_waddr  = {i_q_item.tag, i_q_item.line, i_q_item.word};
        mem_wdata  = i_q_item.wbyte;
        mem_raddr  = {i_q_item.tag, i_q_item.line, {WORD_W{1'b0}}};
        line_we    = 1'b0;
        line_waddr = {r_item.line, r_cnt};
        line_raddr = {i_q_item.line, i_q_item.word};
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_item  = i_q_item;
                    n_cnt   = '0;
                    if (i_q_item.kind == KIND_LOAD) begin
                        mem_we = 1'b1;
                        n_byte = '0;
                        n_hit  = 1'b0;
                    end else if (hit_now) begin
                        n_hit  = 1'b1;
                        n_time = r_time + CNT_W'(1);
                    end else begin
                        n_hit  = 1'b0;
                        n_miss = r_miss + CNT_W'(1);
                        n_time = r_time + CNT_W'(1) + MISS_PENALTY;
                    end
                end
            end
            ST_FILL: begin
                // write the byte that arrived, request the next one
                line_we   = 1'b1;
                mem_raddr = {r_item.tag, r_item.line, r_cnt + 1'b1};
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == r_item.word) begin
                    n_byte = mem_rdata;
                end
                if (r_cnt == WORD_LAST) begin
                    n_tag[r_item.line]    = r_item.tag;
                    n_lvalid[r_item.line] = 1'b1;
                end
            end
            ST_READ: begin
                n_byte = line_rdata;
            end
            ST_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lvalid    <= '0;
            r_miss      <= '0;
            r_time      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lvalid    <= n_lvalid;
            r_miss      <= n_miss;
            r_time      <= n_time;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_cnt  <= n_cnt;
        r_tag  <= n_tag;
        r_byte <= n_byte;
        r_hit  <= n_hit;
        if (out_load) begin
            r_out_byte <= r_byte;
            r_out_hit  <= r_hit;
            r_out_miss <= r_miss;
            r_out_time <= r_time;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_hit;
    assign o_m_tdata  = M_TDATA_W'({r_out_time, r_out_miss, r_out_byte});

endmodule

// File: dv/direct_mapped_cache_read_unit_tb.sv
// Self-checking testbench for the direct-mapped cache read unit.
module direct_mapped_cache_read_unit_tb;
    import dmc_pkg::*;

    localparam int NUM_BLOCKS   = MEMORY_BYTES / LINE_BYTES;
    localparam int LIMIT_CYCLES = 250000;
    localparam int RANDOM_ITEMS = 1260;

    typedef struct packed {
        logic [DATA_W-1:0] rbyte;
        logic              hit;
        logic [CNT_W-1:0]  misses;
        logic [CNT_W-1:0]  elapsed;
    } t_cache_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata;  // address[9:0], write_byte[17:10], zero pad
    logic                 i_s_tuser;  // action
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [M_TDATA_W-1:0] o_m_tdata;  // read_byte[7:0], miss_total[39:8],
                                      // elapsed_time[71:40]
    logic                 o_m_tuser;  // was_hit

    direct_mapped_cache_read_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Shadow copy of the cache and its backing store
    bit [DATA_W-1:0] mem_bytes [MEMORY_BYTES];
    bit              mem_written [MEMORY_BYTES];
    bit              block_full [NUM_BLOCKS];
    int              full_blocks [$];
    int              recent_blocks [$];
    bit [TAG_W-1:0]  line_tags [NUM_LINES];
    bit              line_valid [NUM_LINES];
    bit [DATA_W-1:0] line_data [NUM_LINES][LINE_BYTES];
    bit [CNT_W-1:0]  miss_count;
    bit [CNT_W-1:0]  elapsed_count;

    t_cache_result   pending_results [$];
    t_cache_result   expected_beat;
    t_cache_result   observed_beat;

    int  mismatch_count;
    int  cycle_count;
    int  burst_left;
    int  hold_request;
    int  hold_left;
    int  stall_mode;
    int  mode_left;
    int  ready_left;
    bit  ready_now;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic t_cache_result predict_access(input t_kind kind,
                                                     input logic [ADDR_W-1:0] addr,
                                                     input logic [DATA_W-1:0] wbyte);
        t_cache_result    res;
        int               blk;
        int               ln;
        int               wd;
        logic [TAG_W-1:0] tg;
        bit               all_set;
        res = '0;
        blk = int'(addr[ADDR_W-1:WORD_W]);
        ln  = int'(addr[WORD_W +: LINE_W]);
        wd  = int'(addr[WORD_W-1:0]);
        tg  = addr[ADDR_W-1 -: TAG_W];
        if (kind == KIND_LOAD) begin
            mem_bytes[addr]   = wbyte;
            mem_written[addr] = 1'b1;
            all_set = 1'b1;
            for (int i = 0; i < LINE_BYTES; i++)
                all_set &= mem_written[blk * LINE_BYTES + i];
            if (all_set && !block_full[blk]) begin
                block_full[blk] = 1'b1;
                full_blocks.push_back(blk);
            end
        end else begin
            elapsed_count += 1;
            if (line_valid[ln] && line_tags[ln] == tg) begin
                res.hit = 1'b1;
            end else begin
                miss_count    += 1;
                elapsed_count += 10;
                for (int i = 0; i < LINE_BYTES; i++)
                    line_data[ln][i] = mem_bytes[blk * LINE_BYTES + i];
                line_tags[ln]  = tg;
                line_valid[ln] = 1'b1;
            end
            res.rbyte = line_data[ln][wd];
        end
        res.misses  = miss_count;
        res.elapsed = elapsed_count;
        return res;
    endfunction

    task automatic send_item(input t_kind kind, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] wbyte);
        int gap;
        if (burst_left <= 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 20);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= S_TDATA_W'({wbyte, addr});
        i_s_tuser  <= kind;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_results.push_back(predict_access(kind, addr, wbyte));
        burst_left--;
    endtask

    // Reads only touch blocks whose bytes have all been loaded
    task automatic send_read();
        int blk;
        if (recent_blocks.size() > 0 && $urandom_range(0, 9) < 6)
            blk = recent_blocks[$urandom_range(0, recent_blocks.size() - 1)];
        else
            blk = full_blocks[$urandom_range(0, full_blocks.size() - 1)];
        recent_blocks.push_back(blk);
        if (recent_blocks.size() > 3) void'(recent_blocks.pop_front());
        send_item(KIND_READ, ADDR_W'(blk * LINE_BYTES + $urandom_range(0, LINE_BYTES - 1)),
                  DATA_W'($urandom));
    endtask

    task automatic load_block(input int blk);
        for (int i = 0; i < LINE_BYTES; i++)
            send_item(KIND_LOAD, ADDR_W'(blk * LINE_BYTES + i), DATA_W'($urandom));
    endtask

    task automatic test_directed_corners();
        logic [DATA_W-1:0] pattern [LINE_BYTES];
        pattern = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE};
        for (int i = 0; i < LINE_BYTES; i++)
            send_item(KIND_LOAD, ADDR_W'(i), pattern[i]);
        for (int i = 0; i < LINE_BYTES; i++)
            send_item(KIND_LOAD, ADDR_W'(MEMORY_BYTES - LINE_BYTES + i), ~pattern[i]);
        // cold misses, then hits on the same lines at both ends of a block
        send_item(KIND_READ, ADDR_W'(0), 8'hFF);
        send_item(KIND_READ, ADDR_W'(LINE_BYTES - 1), 8'h00);
        send_item(KIND_READ, ADDR_W'(MEMORY_BYTES - 1), 8'h00);
        send_item(KIND_READ, ADDR_W'(MEMORY_BYTES - LINE_BYTES), 8'hFF);
        // a load leaves the cached copy stale
        send_item(KIND_LOAD, ADDR_W'(3), 8'h3C);
        send_item(KIND_READ, ADDR_W'(3), 8'h00);
    endtask

    task automatic test_line_conflict();
        int blk;
        blk = NUM_BLOCKS - NUM_LINES;  // same line as block 0, highest tag
        load_block(blk);
        send_item(KIND_READ, ADDR_W'(blk * LINE_BYTES), 8'h00);
        send_item(KIND_READ, ADDR_W'(0), 8'h00);
        send_item(KIND_READ, ADDR_W'(blk * LINE_BYTES + LINE_BYTES - 1), 8'h00);
        send_item(KIND_READ, ADDR_W'(MEMORY_BYTES - 1), 8'h00);
    endtask

    task automatic test_output_backpressure();
        burst_left   = 1000;
        hold_request = 300;
        for (int i = 0; i < 16; i++) begin
            if (i % 4 == 3)
                send_item(KIND_LOAD, ADDR_W'($urandom), DATA_W'($urandom));
            else
                send_read();
        end
        burst_left = 0;
    endtask

    task automatic test_random_traffic(input int item_goal);
        int sent;
        int blk;
        int reads;
        sent = 0;
        while (sent < item_goal) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4: begin
                    // fill a whole block, then issue reads that favour recently used blocks, this one among them
                    blk = $urandom_range(0, NUM_BLOCKS - 1);
                    load_block(blk);
                    recent_blocks.push_back(blk);
                    if (recent_blocks.size() > 3) void'(recent_blocks.pop_front());
                    reads = $urandom_range(1, 6);
                    for (int i = 0; i < reads; i++) send_read();
                    sent += LINE_BYTES + reads;
                end
                5, 6, 7, 8: begin
                    send_item(KIND_LOAD, ADDR_W'($urandom), DATA_W'($urandom));
                    sent++;
                end
                default: begin
                    send_read();
                    sent++;
                end
            endcase
        end
    endtask

    // Result checker and receiver stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            observed_beat.rbyte   = o_m_tdata[7:0];
            observed_beat.hit     = o_m_tuser;
            observed_beat.misses  = o_m_tdata[39:8];
            observed_beat.elapsed = o_m_tdata[71:40];
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result beat: byte %h hit %0d misses %0d elapsed %0d",
                             observed_beat.rbyte, observed_beat.hit,
                             observed_beat.misses, observed_beat.elapsed);
            end else begin
                expected_beat = pending_results.pop_front();
                if (observed_beat !== expected_beat) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $write("Mismatch: expected byte %h hit %0d misses %0d elapsed %0d, ",
                               expected_beat.rbyte, expected_beat.hit,
                               expected_beat.misses, expected_beat.elapsed);
                        $display("got byte %h hit %0d misses %0d elapsed %0d",
                                 observed_beat.rbyte, observed_beat.hit,
                                 observed_beat.misses, observed_beat.elapsed);
                    end
                end
            end
        end

        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (mode_left <= 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(50, 300);
        end else begin
            mode_left--;
        end

        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else if (stall_mode == 0) begin
            i_m_tready <= 1'b1;
        end else begin
            if (ready_left <= 0) begin
                ready_now  = !ready_now;
                ready_left = ready_now ? $urandom_range(1, 8)
                           : (stall_mode == 1) ? $urandom_range(1, 3) : $urandom_range(2, 12);
            end else begin
                ready_left--;
            end
            i_m_tready <= ready_now;
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= KIND_LOAD;
        i_m_tready <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_corners();
        test_line_conflict();
        test_output_backpressure();
        test_random_traffic(RANDOM_ITEMS);
        i_s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
